// File: rtl/apbm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the affine point and box map unit.
package apbm_pkg;

   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_COORD_BITS = 32;
   localparam int CSR_IDX_BITS   = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_COEFF_A  = 3'd0,
      REG_COEFF_B  = 3'd1,
      REG_COEFF_C  = 3'd2,
      REG_COEFF_D  = 3'd3,
      REG_OFFSET_E = 3'd4,
      REG_OFFSET_F = 3'd5
   } csr_reg_type;

endpackage

// File: rtl/affine_point_and_box_map_unit.sv
`timescale 1ns / 1ps
// Top level of the affine point and box map unit.
//
//   channel   handshake             payload
//   req_      req_valid/req_stall   func, pos_x, pos_y, size_w, size_h
//   rsp_      rsp_valid/rsp_stall   out_x, out_y, out_w, out_h
//   csr_      csr_valid/csr_ready   csr_index, csr_data
//
// One word per cycle while no stage is stalled; a taken word passes through
// the four register stages: multiply, partial sums, edges, saturation.
// Reset is synchronous; it empties the pipeline and loads the identity matrix.
// A stalled result holds; each stage advances while it is empty or the one
// after it moves, so bubbles close up and req_stall rises only when all are full.
module affine_point_and_box_map_unit
   import apbm_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_size_w,
   input  logic signed [COORD_BITS-1:0] req_size_h,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [COORD_BITS-2:0]        rsp_out_w,
   output logic [COORD_BITS-2:0]        rsp_out_h,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]        csr_data
);

   localparam int PW = 2 * COORD_BITS;
   localparam int EW = PW + 3 - FRAC_BITS;

   logic signed [COORD_BITS-1:0] coeff_a, coeff_b, coeff_c, coeff_d;
   logic signed [COORD_BITS-1:0] offset_e, offset_f;

   logic rdy1, rdy2, rdy3, rdy4;
   logic v1, v2, v3;

   logic signed [PW-1:0]   ax, cy, aw, ch, bx, dy, bw, dh;
   logic signed [PW+2:0]   base_x, base_y;
   logic signed [PW:0]     lo_x, hi_x, lo_y, hi_y;
   logic signed [EW-1:0]   left, right, top, bottom;

   assign csr_ready = 1'b1;
   assign req_stall = !rdy1;

   apbm_csr #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coeff_a   (coeff_a),
      .coeff_b   (coeff_b),
      .coeff_c   (coeff_c),
      .coeff_d   (coeff_d),
      .offset_e  (offset_e),
      .offset_f  (offset_f)
   );

   apbm_mul #(
      .COORD_BITS (COORD_BITS)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .down_ready (rdy2),
      .ready      (rdy1),
      .out_valid  (v1),
      .func       (req_func),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .size_w     (req_size_w),
      .size_h     (req_size_h),
      .coeff_a    (coeff_a),
      .coeff_b    (coeff_b),
      .coeff_c    (coeff_c),
      .coeff_d    (coeff_d),
      .ax         (ax),
      .cy         (cy),
      .aw         (aw),
      .ch         (ch),
      .bx         (bx),
      .dy         (dy),
      .bw         (bw),
      .dh         (dh)
   );

   apbm_sum #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_sum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v1),
      .down_ready (rdy3),
      .ready      (rdy2),
      .out_valid  (v2),
      .ax         (ax),
      .cy         (cy),
      .aw         (aw),
      .ch         (ch),
      .bx         (bx),
      .dy         (dy),
      .bw         (bw),
      .dh         (dh),
      .offset_e   (offset_e),
      .offset_f   (offset_f),
      .base_x     (base_x),
      .base_y     (base_y),
      .lo_x       (lo_x),
      .hi_x       (hi_x),
      .lo_y       (lo_y),
      .hi_y       (hi_y)
   );

   apbm_edge #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2),
      .down_ready (rdy4),
      .ready      (rdy3),
      .out_valid  (v3),
      .base_x     (base_x),
      .base_y     (base_y),
      .lo_x       (lo_x),
      .hi_x       (hi_x),
      .lo_y       (lo_y),
      .hi_y       (hi_y),
      .left       (left),
      .right      (right),
      .top        (top),
      .bottom     (bottom)
   );

   apbm_sat #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_sat (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v3),
      .down_ready (!rsp_stall),
      .ready      (rdy4),
      .out_valid  (rsp_valid),
      .left       (left),
      .right      (right),
      .top        (top),
      .bottom     (bottom),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_w      (rsp_out_w),
      .out_h      (rsp_out_h)
   );

endmodule

// File: rtl/apbm_csr.sv
`timescale 1ns / 1ps
// Matrix coefficient and offset registers with their write port.
module apbm_csr
   import apbm_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]        csr_data,
   output logic signed [COORD_BITS-1:0] coeff_a,
   output logic signed [COORD_BITS-1:0] coeff_b,
   output logic signed [COORD_BITS-1:0] coeff_c,
   output logic signed [COORD_BITS-1:0] coeff_d,
   output logic signed [COORD_BITS-1:0] offset_e,
   output logic signed [COORD_BITS-1:0] offset_f
);

   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1) << FRAC_BITS;

   logic [COORD_BITS-1:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff;
   logic [COORD_BITS-1:0] a_in, b_in, c_in, d_in, e_in, f_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      f_in = f_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_COEFF_A:  a_in = csr_data;
            REG_COEFF_B:  b_in = csr_data;
            REG_COEFF_C:  c_in = csr_data;
            REG_COEFF_D:  d_in = csr_data;
            REG_OFFSET_E: e_in = csr_data;
            REG_OFFSET_F: f_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= ONE;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= ONE;
         e_ff <= '0;
         f_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
         f_ff <= f_in;
      end
   end

   assign coeff_a  = a_ff;
   assign coeff_b  = b_ff;
   assign coeff_c  = c_ff;
   assign coeff_d  = d_ff;
   assign offset_e = e_ff;
   assign offset_f = f_ff;

endmodule

// File: rtl/apbm_mul.sv
`timescale 1ns / 1ps
// Stage one: the eight coefficient products of origin and size.
module apbm_mul
   import apbm_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic                           down_ready,
   output logic                           ready,
   output logic                           out_valid,
   input  logic                           func,
   input  logic signed [COORD_BITS-1:0]   pos_x,
   input  logic signed [COORD_BITS-1:0]   pos_y,
   input  logic signed [COORD_BITS-1:0]   size_w,
   input  logic signed [COORD_BITS-1:0]   size_h,
   input  logic signed [COORD_BITS-1:0]   coeff_a,
   input  logic signed [COORD_BITS-1:0]   coeff_b,
   input  logic signed [COORD_BITS-1:0]   coeff_c,
   input  logic signed [COORD_BITS-1:0]   coeff_d,
   output logic signed [2*COORD_BITS-1:0] ax,
   output logic signed [2*COORD_BITS-1:0] cy,
   output logic signed [2*COORD_BITS-1:0] aw,
   output logic signed [2*COORD_BITS-1:0] ch,
   output logic signed [2*COORD_BITS-1:0] bx,
   output logic signed [2*COORD_BITS-1:0] dy,
   output logic signed [2*COORD_BITS-1:0] bw,
   output logic signed [2*COORD_BITS-1:0] dh
);

   localparam int PW = 2 * COORD_BITS;

   logic                   valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] w_eff, h_eff;
   logic signed [PW-1:0]   ax_ff, cy_ff, aw_ff, ch_ff, bx_ff, dy_ff, bw_ff, dh_ff;
   logic signed [PW-1:0]   ax_in, cy_in, aw_in, ch_in, bx_in, dy_in, bw_in, dh_in;

   assign ready = !valid_ff || down_ready;

   always_comb begin
      w_eff    = func ? size_w : '0;
      h_eff    = func ? size_h : '0;
      valid_in = ready ? in_valid : valid_ff;
      ax_in    = pos_x * coeff_a;
      cy_in    = pos_y * coeff_c;
      aw_in    = w_eff * coeff_a;
      ch_in    = h_eff * coeff_c;
      bx_in    = pos_x * coeff_b;
      dy_in    = pos_y * coeff_d;
      bw_in    = w_eff * coeff_b;
      dh_in    = h_eff * coeff_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ready) begin
         ax_ff <= ax_in;
         cy_ff <= cy_in;
         aw_ff <= aw_in;
         ch_ff <= ch_in;
         bx_ff <= bx_in;
         dy_ff <= dy_in;
         bw_ff <= bw_in;
         dh_ff <= dh_in;
      end
   end

   assign out_valid = valid_ff;
   assign ax = ax_ff;
   assign cy = cy_ff;
   assign aw = aw_ff;
   assign ch = ch_ff;
   assign bx = bx_ff;
   assign dy = dy_ff;
   assign bw = bw_ff;
   assign dh = dh_ff;

endmodule

// File: rtl/apbm_sum.sv
`timescale 1ns / 1ps
// Stage two: origin sums with offset and rounding, and corner spread terms.
module apbm_sum
   import apbm_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic                             down_ready,
   output logic                             ready,
   output logic                             out_valid,
   input  logic signed [2*COORD_BITS-1:0]   ax,
   input  logic signed [2*COORD_BITS-1:0]   cy,
   input  logic signed [2*COORD_BITS-1:0]   aw,
   input  logic signed [2*COORD_BITS-1:0]   ch,
   input  logic signed [2*COORD_BITS-1:0]   bx,
   input  logic signed [2*COORD_BITS-1:0]   dy,
   input  logic signed [2*COORD_BITS-1:0]   bw,
   input  logic signed [2*COORD_BITS-1:0]   dh,
   input  logic signed [COORD_BITS-1:0]     offset_e,
   input  logic signed [COORD_BITS-1:0]     offset_f,
   output logic signed [2*COORD_BITS+2:0]   base_x,
   output logic signed [2*COORD_BITS+2:0]   base_y,
   output logic signed [2*COORD_BITS:0]     lo_x,
   output logic signed [2*COORD_BITS:0]     hi_x,
   output logic signed [2*COORD_BITS:0]     lo_y,
   output logic signed [2*COORD_BITS:0]     hi_y
);

   localparam int PW  = 2 * COORD_BITS;
   localparam int PW1 = PW + 1;
   localparam int ACC = PW + 3;
   localparam logic signed [PW-1:0]  PZERO = '0;
   localparam logic signed [ACC-1:0] HALF  = ACC'(1) << (FRAC_BITS - 1);

   logic                  valid_ff, valid_in;
   logic signed [ACC-1:0] bx_ff, by_ff, bx_in, by_in;
   logic signed [PW1-1:0] lx_ff, hx_ff, ly_ff, hy_ff;
   logic signed [PW1-1:0] lx_in, hx_in, ly_in, hy_in;

   assign ready = !valid_ff || down_ready;

   always_comb begin
      valid_in = ready ? in_valid : valid_ff;
      bx_in = ACC'(ax) + ACC'(cy) + (ACC'(offset_e) <<< FRAC_BITS) + HALF;
      by_in = ACC'(bx) + ACC'(dy) + (ACC'(offset_f) <<< FRAC_BITS) + HALF;
      lx_in = PW1'(aw[PW-1] ? aw : PZERO) + PW1'(ch[PW-1] ? ch : PZERO);
      hx_in = PW1'(aw[PW-1] ? PZERO : aw) + PW1'(ch[PW-1] ? PZERO : ch);
      ly_in = PW1'(bw[PW-1] ? bw : PZERO) + PW1'(dh[PW-1] ? dh : PZERO);
      hy_in = PW1'(bw[PW-1] ? PZERO : bw) + PW1'(dh[PW-1] ? PZERO : dh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ready) begin
         bx_ff <= bx_in;
         by_ff <= by_in;
         lx_ff <= lx_in;
         hx_ff <= hx_in;
         ly_ff <= ly_in;
         hy_ff <= hy_in;
      end
   end

   assign out_valid = valid_ff;
   assign base_x = bx_ff;
   assign base_y = by_ff;
   assign lo_x   = lx_ff;
   assign hi_x   = hx_ff;
   assign lo_y   = ly_ff;
   assign hi_y   = hy_ff;

endmodule

// File: rtl/apbm_edge.sv
`timescale 1ns / 1ps
// Stage three: box edges at the extreme corners per axis, rounding shift on the output.
module apbm_edge
   import apbm_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic                                     down_ready,
   output logic                                     ready,
   output logic                                     out_valid,
   input  logic signed [2*COORD_BITS+2:0]           base_x,
   input  logic signed [2*COORD_BITS+2:0]           base_y,
   input  logic signed [2*COORD_BITS:0]             lo_x,
   input  logic signed [2*COORD_BITS:0]             hi_x,
   input  logic signed [2*COORD_BITS:0]             lo_y,
   input  logic signed [2*COORD_BITS:0]             hi_y,
   output logic signed [2*COORD_BITS+2-FRAC_BITS:0] left,
   output logic signed [2*COORD_BITS+2-FRAC_BITS:0] right,
   output logic signed [2*COORD_BITS+2-FRAC_BITS:0] top,
   output logic signed [2*COORD_BITS+2-FRAC_BITS:0] bottom
);

   localparam int ACC = 2 * COORD_BITS + 3;

   logic                  valid_ff, valid_in;
   logic signed [ACC-1:0] l_ff, r_ff, t_ff, b_ff;
   logic signed [ACC-1:0] l_in, r_in, t_in, b_in;

   assign ready = !valid_ff || down_ready;

   always_comb begin
      valid_in = ready ? in_valid : valid_ff;
      l_in = base_x + ACC'(lo_x);
      r_in = base_x + ACC'(hi_x);
      t_in = base_y + ACC'(lo_y);
      b_in = base_y + ACC'(hi_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ready) begin
         l_ff <= l_in;
         r_ff <= r_in;
         t_ff <= t_in;
         b_ff <= b_in;
      end
   end

   assign out_valid = valid_ff;
   assign left   = l_ff[ACC-1:FRAC_BITS];
   assign right  = r_ff[ACC-1:FRAC_BITS];
   assign top    = t_ff[ACC-1:FRAC_BITS];
   assign bottom = b_ff[ACC-1:FRAC_BITS];

endmodule

// File: rtl/apbm_sat.sv
`timescale 1ns / 1ps
// Stage four: edge saturation, box size and the result register.
module apbm_sat
   import apbm_pkg::*;
#(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic                                     down_ready,
   output logic                                     ready,
   output logic                                     out_valid,
   input  logic signed [2*COORD_BITS+2-FRAC_BITS:0] left,
   input  logic signed [2*COORD_BITS+2-FRAC_BITS:0] right,
   input  logic signed [2*COORD_BITS+2-FRAC_BITS:0] top,
   input  logic signed [2*COORD_BITS+2-FRAC_BITS:0] bottom,
   output logic signed [COORD_BITS-1:0]             out_x,
   output logic signed [COORD_BITS-1:0]             out_y,
   output logic [COORD_BITS-2:0]                    out_w,
   output logic [COORD_BITS-2:0]                    out_h
);

   localparam int EW  = 2 * COORD_BITS + 3 - FRAC_BITS;
   localparam int DW  = EW + 1;
   localparam logic [COORD_BITS-1:0] SMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] SMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [COORD_BITS-2:0] UMAX = '1;

   logic                         valid_ff, valid_in;
   logic signed [DW-1:0]         dx, dy;
   logic [COORD_BITS-1:0]        x_ff, y_ff, x_in, y_in;
   logic [COORD_BITS-2:0]        w_ff, h_ff, w_in, h_in;

   assign ready = !valid_ff || down_ready;

   always_comb begin
      valid_in = ready ? in_valid : valid_ff;
      dx = DW'(right) - DW'(left);
      dy = DW'(bottom) - DW'(top);

      if ((&left[EW-1:COORD_BITS-1]) || !(|left[EW-1:COORD_BITS-1])) begin
         x_in = left[COORD_BITS-1:0];
      end else begin
         x_in = left[EW-1] ? SMIN : SMAX;
      end
      if ((&top[EW-1:COORD_BITS-1]) || !(|top[EW-1:COORD_BITS-1])) begin
         y_in = top[COORD_BITS-1:0];
      end else begin
         y_in = top[EW-1] ? SMIN : SMAX;
      end
      w_in = (|dx[DW-1:COORD_BITS-1]) ? UMAX : dx[COORD_BITS-2:0];
      h_in = (|dy[DW-1:COORD_BITS-1]) ? UMAX : dy[COORD_BITS-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ready) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= w_in;
         h_ff <= h_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_w = w_ff;
   assign out_h = h_ff;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the affine point and box map unit, with scoreboard and stimulus.
module tb_top
   import apbm_pkg::*;
;

   localparam int CB           = DEF_COORD_BITS;
   localparam int FRAC         = DEF_FRAC_BITS;
   localparam int NUM_REGS     = 6;
   localparam int PIPE_DEPTH   = 4;
   localparam int RESET_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_WORDS  = 90;
   localparam int HOLD_WORDS   = 30;
   localparam int HOLD_CYCLES  = 80;
   localparam int SMALL_SPAN   = 32'h0040_0000;
   localparam int COEFF_SPAN   = 32'h0008_0000;

   localparam int KIND_MODERATE = 0;
   localparam int KIND_FULL     = 1;
   localparam int KIND_EXTREME  = 2;
   localparam int KIND_MIXED    = 3;

   localparam logic FUNC_POINT = 1'b0;
   localparam logic FUNC_BOX   = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

   localparam logic [CB-1:0] C_MAX = 32'h7fff_ffff;
   localparam logic [CB-1:0] C_MIN = 32'h8000_0000;
   localparam logic [CB-1:0] C_ONE = 32'h0001_0000;
   localparam logic [CB-1:0] C_HALF = 32'h0000_8000;

   typedef logic signed [79:0] wide_type;

   localparam wide_type EDGE_MAX   = (wide_type'(1) <<< (CB - 1)) - wide_type'(1);
   localparam wide_type EDGE_MIN   = -(wide_type'(1) <<< (CB - 1));
   localparam wide_type ROUND_HALF = wide_type'(1) <<< (FRAC - 1);

   typedef struct packed {
      logic                 func;
      logic signed [CB-1:0] pos_x;
      logic signed [CB-1:0] pos_y;
      logic signed [CB-1:0] size_w;
      logic signed [CB-1:0] size_h;
   } map_req_type;

   typedef struct packed {
      logic signed [CB-1:0] out_x;
      logic signed [CB-1:0] out_y;
      logic [CB-2:0]        out_w;
      logic [CB-2:0]        out_h;
   } map_rsp_type;

   class box_map_scoreboard;
      logic [CB-1:0] coeff[NUM_REGS];
      map_rsp_type   pending_results[$];
      int            errors;
      int            checked;
      int            boxes;
      int            points;

      function new();
         coeff[REG_COEFF_A]  = C_ONE;
         coeff[REG_COEFF_B]  = '0;
         coeff[REG_COEFF_C]  = '0;
         coeff[REG_COEFF_D]  = C_ONE;
         coeff[REG_OFFSET_E] = '0;
         coeff[REG_OFFSET_F] = '0;
         errors  = 0;
         checked = 0;
         boxes   = 0;
         points  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CB-1:0] val);
         if (idx <= REG_OFFSET_F) begin
            coeff[idx] = val;
         end
      endfunction

      function wide_type map_axis(wide_type u, wide_type v, wide_type mu, wide_type mv,
                                  wide_type off);
         wide_type acc;
         acc = u * mu + v * mv + (off <<< FRAC) + ROUND_HALF;
         return acc >>> FRAC;
      endfunction

      function logic [CB-1:0] clamp_edge(wide_type v);
         if (v > EDGE_MAX) begin
            return EDGE_MAX[CB-1:0];
         end
         if (v < EDGE_MIN) begin
            return EDGE_MIN[CB-1:0];
         end
         return v[CB-1:0];
      endfunction

      function logic [CB-2:0] clamp_size(wide_type v);
         if (v > EDGE_MAX) begin
            return EDGE_MAX[CB-2:0];
         end
         return v[CB-2:0];
      endfunction

      function map_rsp_type map_word(map_req_type w);
         wide_type    xs[4];
         wide_type    ys[4];
         wide_type    m_a, m_b, m_c, m_d, m_e, m_f;
         wide_type    px, py, lft, rgt, top, bot;
         map_rsp_type r;
         m_a = $signed(coeff[REG_COEFF_A]);
         m_b = $signed(coeff[REG_COEFF_B]);
         m_c = $signed(coeff[REG_COEFF_C]);
         m_d = $signed(coeff[REG_COEFF_D]);
         m_e = $signed(coeff[REG_OFFSET_E]);
         m_f = $signed(coeff[REG_OFFSET_F]);
         xs[0] = $signed(w.pos_x);
         ys[0] = $signed(w.pos_y);
         if (w.func == FUNC_POINT) begin
            r.out_x = clamp_edge(map_axis(xs[0], ys[0], m_a, m_c, m_e));
            r.out_y = clamp_edge(map_axis(xs[0], ys[0], m_b, m_d, m_f));
            r.out_w = '0;
            r.out_h = '0;
            return r;
         end
         xs[1] = xs[0] + $signed(w.size_w);
         ys[1] = ys[0];
         xs[2] = xs[1];
         ys[2] = ys[0] + $signed(w.size_h);
         xs[3] = xs[0];
         ys[3] = ys[2];
         lft = map_axis(xs[0], ys[0], m_a, m_c, m_e);
         rgt = lft;
         top = map_axis(xs[0], ys[0], m_b, m_d, m_f);
         bot = top;
         for (int i = 1; i < 4; i++) begin
            px = map_axis(xs[i], ys[i], m_a, m_c, m_e);
            py = map_axis(xs[i], ys[i], m_b, m_d, m_f);
            if (px < lft) lft = px;
            if (px > rgt) rgt = px;
            if (py < top) top = py;
            if (py > bot) bot = py;
         end
         r.out_x = clamp_edge(lft);
         r.out_y = clamp_edge(top);
         r.out_w = clamp_size(rgt - lft);
         r.out_h = clamp_size(bot - top);
         return r;
      endfunction

      function void note_input(map_req_type w);
         if (w.func == FUNC_BOX) begin
            boxes++;
         end else begin
            points++;
         end
         pending_results.push_back(map_word(w));
      endfunction

      function void check_result(map_rsp_type got);
         map_rsp_type want;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("unexpected result word: x=%h y=%h w=%h h=%h",
                        got.out_x, got.out_y, got.out_w, got.out_h);
            end
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
             got.out_w !== want.out_w || got.out_h !== want.out_h) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch on word %0d: want x=%h y=%h w=%h h=%h", checked,
                        want.out_x, want.out_y, want.out_w, want.out_h);
               $display("                       got  x=%h y=%h w=%h h=%h",
                        got.out_x, got.out_y, got.out_w, got.out_h);
            end
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_func;
   logic signed [CB-1:0]       req_pos_x;
   logic signed [CB-1:0]       req_pos_y;
   logic signed [CB-1:0]       req_size_w;
   logic signed [CB-1:0]       req_size_h;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [CB-1:0]       rsp_out_x;
   logic signed [CB-1:0]       rsp_out_y;
   logic [CB-2:0]              rsp_out_w;
   logic [CB-2:0]              rsp_out_h;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_BITS-1:0]    csr_index;
   logic [CB-1:0]              csr_data;

   box_map_scoreboard map_check;
   bit                send_gaps;
   bit                rsp_gaps;
   bit                hold_req;
   int                settings_loaded;

   affine_point_and_box_map_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_size_w (req_size_w),
      .req_size_h (req_size_h),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_w  (rsp_out_w),
      .rsp_out_h  (rsp_out_h),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic map_req_type make_word(logic func, logic [CB-1:0] x, logic [CB-1:0] y,
                                             logic [CB-1:0] w, logic [CB-1:0] h);
      map_req_type m;
      m.func   = func;
      m.pos_x  = x;
      m.pos_y  = y;
      m.size_w = w;
      m.size_h = h;
      return m;
   endfunction

   function automatic logic [CB-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return C_MAX;
               1: return C_MIN;
               2: return '0;
               3: return '1;
               default: return C_ONE;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return CB'($urandom_range(0, SMALL_SPAN)) - CB'(SMALL_SPAN / 2);
      endcase
   endfunction

   function automatic logic [CB-1:0] coeff_for(int kind);
      int k;
      k = (kind == KIND_MIXED) ? $urandom_range(KIND_MODERATE, KIND_EXTREME) : kind;
      if (k == KIND_FULL) begin
         return $urandom;
      end
      if (k == KIND_EXTREME) begin
         case ($urandom_range(0, 5))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            4: return C_ONE;
            default: return -C_ONE;
         endcase
      end
      return CB'($urandom_range(0, COEFF_SPAN)) - CB'(COEFF_SPAN / 2);
   endfunction

   function automatic map_req_type random_word();
      return make_word(($urandom_range(0, 1) == 0) ? FUNC_POINT : FUNC_BOX,
                       pick_coord(), pick_coord(), pick_coord(), pick_coord());
   endfunction

   task automatic offer_word(input map_req_type w);
      req_valid  <= 1'b1;
      req_func   <= w.func;
      req_pos_x  <= w.pos_x;
      req_pos_y  <= w.pos_y;
      req_size_w <= w.size_w;
      req_size_h <= w.size_h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      map_check.note_input(w);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_words(input int count);
      for (int i = 0; i < count; i++) begin
         offer_word(random_word());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (map_check.outstanding() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [CB-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      map_check.write_reg(idx, val);
   endtask

   task automatic set_matrix(input logic [CB-1:0] a, input logic [CB-1:0] b,
                             input logic [CB-1:0] c, input logic [CB-1:0] d,
                             input logic [CB-1:0] e, input logic [CB-1:0] f);
      csr_write(REG_COEFF_A, a);
      csr_write(REG_COEFF_B, b);
      csr_write(REG_COEFF_C, c);
      csr_write(REG_COEFF_D, d);
      csr_write(REG_OFFSET_E, e);
      csr_write(REG_OFFSET_F, f);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin : rsp_side
      int          burst;
      int          hold;
      map_rsp_type got;
      burst = 0;
      hold  = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.out_x = rsp_out_x;
            got.out_y = rsp_out_y;
            got.out_w = rsp_out_w;
            got.out_h = rsp_out_h;
            map_check.check_result(got);
         end
         if (hold_req) begin
            hold     = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int kind;
      map_check       = new();
      send_gaps       = 1'b0;
      rsp_gaps        = 1'b0;
      hold_req        = 1'b0;
      settings_loaded = 1;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_func   <= FUNC_POINT;
      req_pos_x  <= '0;
      req_pos_y  <= '0;
      req_size_w <= '0;
      req_size_h <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_COEFF_A;
      csr_data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // identity matrix from reset: extremes, ignored sizes, negative and overflowing boxes
      offer_word(make_word(FUNC_POINT, '0, '0, '0, '0));
      offer_word(make_word(FUNC_POINT, C_MAX, C_MAX, C_MIN, C_MAX));
      offer_word(make_word(FUNC_POINT, C_MIN, C_MIN, '1, '1));
      offer_word(make_word(FUNC_POINT, '1, 32'd1, C_ONE, C_ONE));
      offer_word(make_word(FUNC_BOX, '0, '0, C_ONE, C_ONE));
      offer_word(make_word(FUNC_BOX, 10 * C_ONE, -5 * C_ONE, -3 * C_ONE, -2 * C_ONE));
      offer_word(make_word(FUNC_BOX, C_MAX, C_MAX, C_MAX, C_MAX));
      offer_word(make_word(FUNC_BOX, C_MIN, C_MIN, C_MIN, C_MIN));
      offer_word(make_word(FUNC_BOX, C_MIN, C_MAX, C_MAX, C_MIN));
      offer_word(make_word(FUNC_BOX, '0, '0, '0, '0));

      // half-step terms hit the round-half-up cases
      drain();
      set_matrix(C_HALF, -C_HALF, C_ONE + C_HALF, C_HALF, 32'd1, '1);
      offer_word(make_word(FUNC_POINT, 32'd1, '0, '0, '0));
      offer_word(make_word(FUNC_POINT, '1, '0, '0, '0));
      offer_word(make_word(FUNC_POINT, 32'd1, 32'd1, '0, '0));
      offer_word(make_word(FUNC_POINT, '1, '1, '0, '0));
      offer_word(make_word(FUNC_BOX, 32'd1, 32'd1, 32'd1, 32'd1));
      offer_word(make_word(FUNC_BOX, -32'd3, -32'd3, 32'd2, 32'd2));

      drain();
      set_matrix(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN);
      offer_word(make_word(FUNC_POINT, C_MAX, C_MAX, '0, '0));
      offer_word(make_word(FUNC_POINT, C_MIN, C_MIN, '0, '0));
      offer_word(make_word(FUNC_BOX, C_MIN, C_MIN, C_MAX, C_MAX));
      offer_word(make_word(FUNC_BOX, '0, '0, '1, '1));

      drain();
      set_matrix(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX);
      offer_word(make_word(FUNC_POINT, C_MIN, C_MIN, '0, '0));
      offer_word(make_word(FUNC_BOX, C_MAX, C_MIN, C_MIN, C_MAX));

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         if (p == 3 || p == 5) begin
            csr_write(REG_SPARE_LO, $urandom);
            csr_write(REG_SPARE_HI, $urandom);
         end
         kind = (p < KIND_MIXED) ? p : KIND_MIXED;
         set_matrix(coeff_for(kind), coeff_for(kind), coeff_for(kind),
                    coeff_for(kind), coeff_for(kind), coeff_for(kind));
         if (p < 4) begin
            send_gaps = p[0];
            rsp_gaps  = p[1];
         end else if (p == NUM_PHASES - 1) begin
            send_gaps = 1'b0;
            rsp_gaps  = 1'b0;
         end else begin
            send_gaps = 1'($urandom_range(0, 1));
            rsp_gaps  = 1'($urandom_range(0, 1));
         end
         if (p == 2) begin
            // hold the receiver while words keep coming so the pipe backs up
            hold_req  = 1'b1;
            send_gaps = 1'b0;
            send_words(HOLD_WORDS);
            send_gaps = 1'b1;
         end
         if (p == 4) begin
            send_words(PHASE_WORDS / 2);
            drain();
            send_words(PHASE_WORDS - PHASE_WORDS / 2);
         end else begin
            send_words(PHASE_WORDS);
         end
      end
      drain();

      $display("summary: %0d words checked (%0d boxes, %0d points) over %0d matrix settings",
               map_check.checked, map_check.boxes, map_check.points, settings_loaded);
      $display("summary: extremes, rounding, saturation, long receiver hold, %0d failures",
               map_check.errors);
      if (map_check.errors == 0 && map_check.outstanding() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
